// ===== rtl/fwrl_pkg.sv =====
package fwrl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int EVICT_W       = 7;

  localparam logic [15:0]        LIMIT_AT_RESET  = 16'd100;
  localparam logic [15:0]        WINDOW_AT_RESET = 16'd60;
  localparam logic [EVICT_W-1:0] EVICTED_MAX     = {EVICT_W{1'b1}};

  localparam logic [1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_CLEANUP = 1'b1;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] count;
    logic [31:0] win_begin;
  } entry_t;

  typedef struct packed {
    logic [15:0] request_limit;
    logic [15:0] window_length;
  } cfg_t;

  typedef struct packed {
    logic               allowed;
    logic               new_client;
    logic               table_full;
    logic [EVICT_W-1:0] evicted_count;
  } res_t;

endpackage

// ===== rtl/fwrl_entry_ram.sv =====
module fwrl_entry_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fwrl_ctrl.sv =====
module fwrl_ctrl import fwrl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             item_op,
  input  logic [31:0]      item_address,
  input  logic [31:0]      item_now,
  input  cfg_t             cfg,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             ram_rd_en,
  output logic [IDX_W-1:0] ram_rd_addr,
  input  entry_t           ram_rd_data,
  output logic             ram_wr_en,
  output logic [IDX_W-1:0] ram_wr_addr,
  output entry_t           ram_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  localparam logic [IDX_W:0]   SWEEP_END = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

  state_t             state;
  logic [IDX_W:0]     rd_idx;
  logic               rd_pend;
  logic [IDX_W-1:0]   proc_idx;
  logic               op_q;
  logic [31:0]        addr_q;
  logic [31:0]        now_q;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [15:0]        hit_count;
  logic [31:0]        hit_start;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [EVICT_W-1:0] evicted;
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic        proc_valid;
  logic [31:0] sweep_age;
  logic [31:0] age_limit;
  logic        stale;
  logic [31:0] elapsed;
  logic        expired;
  logic        at_limit;
  logic        insert;
  logic        handoff;

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_FINISH);
  assign handoff    = res_valid && res_ready;

  assign ram_rd_en   = (state == S_SWEEP) && (rd_idx != SWEEP_END);
  assign ram_rd_addr = rd_idx[IDX_W-1:0];

  assign proc_valid = entry_valid[proc_idx];
  assign sweep_age  = now_q - ram_rd_data.win_begin;
  assign age_limit  = {15'b0, cfg.window_length, 1'b0};
  assign stale      = proc_valid && (sweep_age >= age_limit);

  assign elapsed  = now_q - hit_start;
  assign expired  = elapsed >= {16'b0, cfg.window_length};
  assign at_limit = hit_count >= cfg.request_limit;
  assign insert   = (op_q == OP_REQUEST) && !hit && free_found;

  always_comb begin
    res                 = '0;
    ram_wr_en           = 1'b0;
    ram_wr_addr         = hit_idx;
    ram_wr_data.address = addr_q;
    ram_wr_data.count   = 16'd1;
    ram_wr_data.win_begin = now_q;
    if (op_q == OP_CLEANUP) begin
      res.evicted_count = evicted;
    end else if (!hit) begin
      res.allowed     = 1'b1;
      res.new_client  = free_found;
      res.table_full  = !free_found;
      ram_wr_en       = handoff && free_found;
      ram_wr_addr     = free_idx;
    end else if (expired) begin
      res.allowed = 1'b1;
      ram_wr_en   = handoff;
    end else if (!at_limit) begin
      res.allowed           = 1'b1;
      ram_wr_en             = handoff;
      ram_wr_data.count     = hit_count + 16'd1;
      ram_wr_data.win_begin = hit_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_pend     <= 1'b0;
      entry_valid <= '0;
    end else begin
      rd_pend <= ram_rd_en;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op_q       <= item_op;
            addr_q     <= item_address;
            now_q      <= item_now;
            rd_idx     <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            evicted    <= '0;
            state      <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (ram_rd_en) begin
            rd_idx   <= rd_idx + 1'b1;
            proc_idx <= rd_idx[IDX_W-1:0];
          end
          if (rd_pend) begin
            if (op_q == OP_CLEANUP) begin
              if (stale) begin
                entry_valid[proc_idx] <= 1'b0;
                if (evicted != EVICTED_MAX) begin
                  evicted <= evicted + 1'b1;
                end
              end
            end else if (proc_valid) begin
              if (!hit && (ram_rd_data.address == addr_q)) begin
                hit       <= 1'b1;
                hit_idx   <= proc_idx;
                hit_count <= ram_rd_data.count;
                hit_start <= ram_rd_data.win_begin;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
            if (proc_idx == LAST_IDX) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (handoff) begin
            if (insert) begin
              entry_valid[free_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/per_client_fixed_window_rate_limiter_core.sv =====
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// in       | in_valid/in_ready   | operation, client_address, now_seconds
// out      | out_valid/out_ready | allowed, new_client, table_full, evicted_count
// cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each transaction walks the whole table through the entry memory read port
// before its result is ready. One transaction is in flight; the next is taken
// once the result moves to the output register. Reset clears the valid flags
// and restores request_limit 100 and window_length 60. While the output is
// stalled, a finished result waits in the controller and no new transaction
// is accepted.
module per_client_fixed_window_rate_limiter_core import fwrl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [31:0]        client_address,
  input  logic [31:0]        now_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               allowed,
  output logic               new_client,
  output logic               table_full,
  output logic [EVICT_W-1:0] evicted_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t             cfg;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           ram_rd_data;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_limit <= LIMIT_AT_RESET;
      cfg.window_length <= WINDOW_AT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REQUEST_LIMIT: cfg.request_limit <= cfg_data;
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      allowed       <= res.allowed;
      new_client    <= res.new_client;
      table_full    <= res.table_full;
      evicted_count <= res.evicted_count;
    end
  end

  fwrl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .item_ready   (in_ready),
    .item_op      (operation),
    .item_address (client_address),
    .item_now     (now_seconds),
    .cfg          (cfg),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data)
  );

  fwrl_entry_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fwrl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 80;
  localparam int PRINT_CAP   = 100;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               operation      = OP_REQUEST;
  logic [31:0]        client_address = '0;
  logic [31:0]        now_seconds    = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               allowed;
  logic               new_client;
  logic               table_full;
  logic [EVICT_W-1:0] evicted_count;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index      = REG_REQUEST_LIMIT;
  logic [15:0]        cfg_data       = '0;

  bit          idling_on = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  bit          slot_used [TABLE_ENTRIES];
  entry_t      slot_entry [TABLE_ENTRIES];
  cfg_t        limit_cfg;
  res_t        pending_results [$];
  logic [31:0] client_pool [POOL_SIZE];

  per_client_fixed_window_rate_limiter_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .client_address (client_address),
    .now_seconds    (now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .allowed        (allowed),
    .new_client     (new_client),
    .table_full     (table_full),
    .evicted_count  (evicted_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= !idling_on || ($urandom_range(99) >= 10);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic res_t limiter_predict(input logic op, input logic [31:0] addr,
                                           input logic [31:0] ts);
    int          hit;
    int          free_idx;
    int unsigned evicted;
    logic [31:0] elapsed;
    logic [31:0] age_limit;
    res_t        r;
    r = '0;
    if (op == OP_CLEANUP) begin
      evicted   = 0;
      age_limit = {15'd0, limit_cfg.window_length, 1'b0};
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        elapsed = ts - slot_entry[i].win_begin;
        if (slot_used[i] && elapsed >= age_limit) begin
          slot_used[i] = 1'b0;
          evicted++;
        end
      end
      r.evicted_count = (evicted > EVICTED_MAX) ? EVICTED_MAX : evicted[EVICT_W-1:0];
      return r;
    end
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_entry[i].address == addr) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r.allowed = 1'b1;
    if (hit < 0) begin
      if (free_idx < 0) begin
        r.table_full = 1'b1;
      end else begin
        slot_used[free_idx]            = 1'b1;
        slot_entry[free_idx].address   = addr;
        slot_entry[free_idx].count     = 16'd1;
        slot_entry[free_idx].win_begin = ts;
        r.new_client                   = 1'b1;
      end
      return r;
    end
    elapsed = ts - slot_entry[hit].win_begin;
    if (elapsed >= {16'd0, limit_cfg.window_length}) begin
      slot_entry[hit].count     = 16'd1;
      slot_entry[hit].win_begin = ts;
    end else if (slot_entry[hit].count >= limit_cfg.request_limit) begin
      r.allowed = 1'b0;
    end else begin
      slot_entry[hit].count = slot_entry[hit].count + 16'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      limit_cfg.request_limit = LIMIT_AT_RESET;
      limit_cfg.window_length = WINDOW_AT_RESET;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction waiting");
        end else begin
          want = pending_results.pop_front();
          if (allowed !== want.allowed)
            report_mismatch($sformatf("allowed %b, want %b", allowed, want.allowed));
          if (new_client !== want.new_client)
            report_mismatch($sformatf("new_client %b, want %b", new_client, want.new_client));
          if (table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, want %b", table_full, want.table_full));
          if (evicted_count !== want.evicted_count)
            report_mismatch($sformatf("evicted_count %0d, want %0d",
                                      evicted_count, want.evicted_count));
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(limiter_predict(operation, client_address, now_seconds));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REQUEST_LIMIT: limit_cfg.request_limit = cfg_data;
          REG_WINDOW_LENGTH: limit_cfg.window_length = cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] addr, input logic [31:0] ts);
    if (idling_on) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    operation      <= op;
    client_address <= addr;
    now_seconds    <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] limit, input logic [15:0] window);
    write_register(REG_REQUEST_LIMIT, limit);
    write_register(REG_WINDOW_LENGTH, window);
  endtask

  // default registers, address and time extremes, wrap and backwards time
  task automatic test_reset_values();
    send_item(OP_REQUEST, 32'h0000_0000, 32'd0);
    send_item(OP_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_REQUEST, 32'h0000_0000, 32'd59);
    send_item(OP_REQUEST, 32'h0000_0000, 32'd60);
    send_item(OP_REQUEST, 32'hFFFF_FFFF, 32'd5);
    send_item(OP_REQUEST, 32'h0000_0000, 32'd10);
    send_item(OP_CLEANUP, 32'hFFFF_FFFF, 32'd129);
    send_item(OP_CLEANUP, 32'h0000_0000, 32'd130);
    send_item(OP_CLEANUP, 32'hA5A5_5A5A, 32'd131);
  endtask

  // limit reached, window expiry, zero limit, zero window
  task automatic test_limit_edges();
    set_limits(16'd2, 16'd5);
    send_item(OP_REQUEST, 32'hC0A8_0001, 32'd100);
    send_item(OP_REQUEST, 32'hC0A8_0001, 32'd101);
    send_item(OP_REQUEST, 32'hC0A8_0001, 32'd102);
    send_item(OP_REQUEST, 32'hC0A8_0001, 32'd104);
    send_item(OP_REQUEST, 32'hC0A8_0001, 32'd105);
    send_item(OP_CLEANUP, 32'd0, 32'd114);
    send_item(OP_CLEANUP, 32'd0, 32'd115);
    set_limits(16'd0, 16'd5);
    send_item(OP_REQUEST, 32'h0A00_0002, 32'd200);
    send_item(OP_REQUEST, 32'h0A00_0002, 32'd201);
    send_item(OP_REQUEST, 32'h0A00_0002, 32'd205);
    set_limits(16'd1, 16'd0);
    send_item(OP_REQUEST, 32'h0A00_0002, 32'd205);
    send_item(OP_REQUEST, 32'h0A00_0002, 32'd205);
    send_item(OP_REQUEST, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_CLEANUP, 32'd0, 32'h8000_0000);
  endtask

  // fill every slot, overflow untracked, then sweep the lot
  task automatic test_table_full();
    logic [31:0] base;
    logic [31:0] addr;
    base = $urandom;
    set_limits(16'd3, 16'd1000);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      addr = $urandom;
      client_pool[i % POOL_SIZE] = addr;
      send_item(OP_REQUEST, addr, base + i);
    end
    for (int i = 0; i < 4; i++) send_item(OP_REQUEST, $urandom, base + 70);
    for (int i = 0; i < 5; i++) send_item(OP_REQUEST, client_pool[1], base + 80);
    send_item(OP_CLEANUP, $urandom, base + 1999);
    send_item(OP_CLEANUP, $urandom, base + 2100);
  endtask

  task automatic run_traffic(input logic [15:0] limit, input logic [15:0] window,
                             input int n_items, input bit idle_enable);
    logic [31:0] clock_s;
    logic [31:0] addr;
    logic        op;
    int unsigned pick;
    int unsigned hot_n;
    set_limits(limit, window);
    idling_on = idle_enable;
    foreach (client_pool[i]) client_pool[i] = $urandom;
    hot_n   = $urandom_range(3, 10);
    clock_s = $urandom;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 50)      clock_s = clock_s;
      else if (pick < 90) clock_s = clock_s + 1;
      else if (pick < 98) clock_s = clock_s + $urandom_range(2 * window + 2);
      else                clock_s = clock_s + $urandom;
      op   = ($urandom_range(99) < 8) ? OP_CLEANUP : OP_REQUEST;
      pick = $urandom_range(99);
      if (pick < 65)      addr = client_pool[$urandom_range(hot_n - 1)];
      else if (pick < 95) addr = client_pool[$urandom_range(POOL_SIZE - 1)];
      else                addr = $urandom;
      send_item(op, addr, clock_s);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_values();
    test_limit_edges();
    test_table_full();
    run_traffic(16'd1, 16'd1, 250, 1'b1);
    run_traffic(16'd4, 16'd20, 400, 1'b0);
    run_traffic(16'd65535, 16'd65535, 250, 1'b1);
    run_traffic(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 250, 1'b1);
    run_traffic(16'd2, 16'd3, 250, 1'b1);
    run_traffic(16'($urandom_range(1, 8)), 16'($urandom_range(1, 100)), 350, 1'b1);
    settle_idle();
    repeat (80) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== per_client_fixed_window_rate_limiter_core.f =====
rtl/fwrl_pkg.sv
rtl/fwrl_entry_ram.sv
rtl/fwrl_ctrl.sv
rtl/per_client_fixed_window_rate_limiter_core.sv
bench/testbench.sv
